// ----- rtl/hts_pkg.sv -----
// Package with the shared types, codes and constants of the hybrid tick task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int NW          = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_ADD      = 2'd1;
	localparam logic [1:0] OP_DELETE   = 2'd2;
	localparam logic [1:0] OP_DISPATCH = 2'd3;

	localparam logic [1:0] KIND_RUN  = 2'd0;
	localparam logic [1:0] KIND_SLOT = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  slot;
		logic [7:0]  job_id;
		logic [15:0] start_delay;
		logic [15:0] period;
		logic        cooperative;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] job;
		logic [3:0] slot_index;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  job;
		logic [15:0] delay;
		logic [15:0] period;
		logic        coop;
		logic [15:0] pending;
	} entry_t;

	typedef struct packed {
		logic   run;
		logic   wr;
		logic   valid;
		entry_t entry;
	} upd_t;

endpackage

`default_nettype wire

// ----- rtl/hts_slot_unit.sv -----
// Shared slot update unit: one 16-bit incrementer/decrementer and the tick and dispatch rules.
`timescale 1ns / 1ps
`default_nettype none

module hts_slot_unit (
	input  wire logic            dispatch,
	input  wire logic            valid,
	input  wire hts_pkg::entry_t ent,
	output hts_pkg::upd_t        upd
);

	logic [15:0] add_a;
	logic        add_dec;
	logic [15:0] sum;

	always_comb begin
		add_a   = ent.delay;
		add_dec = 1'b1;
		if (dispatch) begin
			add_a = ent.pending;
		end else if (ent.delay == 16'd0) begin
			add_a   = ent.pending;
			add_dec = 1'b0;
		end
	end

	assign sum = add_a + (add_dec ? 16'hFFFF : 16'd1);

	always_comb begin
		upd       = '0;
		upd.entry = ent;
		upd.valid = valid;
		if (valid) begin
			if (dispatch) begin
				if (ent.coop && ent.pending != 16'd0) begin
					upd.run           = 1'b1;
					upd.wr            = 1'b1;
					upd.entry.pending = sum;
					if (ent.period == 16'd0) begin
						upd.valid         = 1'b0;
						upd.entry.pending = 16'd0;
					end
				end
			end else if (ent.delay != 16'd0) begin
				upd.wr          = 1'b1;
				upd.entry.delay = sum;
			end else begin
				upd.wr = 1'b1;
				if (ent.coop) begin
					if (ent.pending != 16'hFFFF) begin
						upd.entry.pending = sum;
					end
				end else begin
					upd.run = 1'b1;
					if (ent.period == 16'd0) begin
						upd.valid         = 1'b0;
						upd.entry.pending = 16'd0;
					end
				end
				if (ent.period != 16'd0) begin
					upd.entry.delay = ent.period;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/hybrid_tick_task_scheduler_core.sv -----
// Top level of the hybrid tick task scheduler: slot table, scan sequencer and result register.
// The request channel (req_valid, req_ready, req) carries one operation per transaction:
// tick, add task, delete slot or dispatch cooperative tasks. The response channel
// (rsp_valid, rsp_ready, rsp) returns one or more results per request; the final one has
// last set. Tick and dispatch scan the slot table one slot per clock while the scan is not
// stalled, through a single slot update unit and one read port of the slot memory.
// Add scans the valid bits one slot per cycle. Only one request is in work at a time;
// req_ready is high only while the block is idle. Run results found during a scan wait in a
// holding register; when a further run result is found while the holding register and the
// response register are both full, the scan pauses on that slot without losing anything. A
// stalled receiver therefore stops the scan but never drops results. At most 16 results are
// reported per request. Reset clears every valid bit, so the table comes up empty at once;
// the slot memory itself is not cleared and needs no clearing pass, because the contents of
// a free slot are never used.
`timescale 1ns / 1ps
`default_nettype none

module hybrid_tick_task_scheduler_core #(
	parameter int SLOTS = hts_pkg::SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire hts_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output hts_pkg::rsp_t      rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_SCAN, ST_FIN} state_t;

	state_t                   state_q;
	logic [IW-1:0]            idx_q;
	logic [hts_pkg::NW-1:0]   n_q;
	logic [SLOTS-1:0]         valid_q;
	logic                     held_vld_q;
	logic                     rsp_vld_q;
	hts_pkg::rsp_t            held_q;
	hts_pkg::rsp_t            rsp_q;
	hts_pkg::req_t            req_q;

	hts_pkg::entry_t          mem [SLOTS];
	hts_pkg::entry_t          rdata_q;

	hts_pkg::upd_t            upd;
	hts_pkg::entry_t          wdata;
	hts_pkg::rsp_t            push_data;
	logic [IW-1:0]            raddr;
	logic                     we;
	logic                     push;
	logic                     last_slot;
	logic                     can_push;
	logic                     rec;
	logic                     stall;
	logic                     free;
	logic                     accept;

	hts_slot_unit u_unit (
		.dispatch(req_q.op == hts_pkg::OP_DISPATCH),
		.valid   (valid_q[idx_q]),
		.ent     (rdata_q),
		.upd     (upd)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	always_comb begin
		last_slot = (idx_q == IW'(SLOTS - 1));
		can_push  = !rsp_vld_q || rsp_ready;
		free      = !valid_q[idx_q];
		rec       = (state_q == ST_SCAN) && upd.run && (n_q < hts_pkg::NW'(hts_pkg::MAX_RESULTS));
		stall     = rec && held_vld_q && !can_push;

		raddr = '0;
		if (state_q == ST_SCAN) begin
			if (stall) begin
				raddr = idx_q;
			end else if (!last_slot) begin
				raddr = idx_q + IW'(1);
			end
		end

		we    = 1'b0;
		wdata = upd.entry;
		if (state_q == ST_SCAN && !stall && upd.wr) begin
			we = 1'b1;
		end
		if (state_q == ST_ADD && free) begin
			we            = 1'b1;
			wdata.job     = req_q.job_id;
			wdata.delay   = req_q.start_delay;
			wdata.period  = req_q.period;
			wdata.coop    = req_q.cooperative;
			wdata.pending = 16'd0;
		end

		push      = 1'b0;
		push_data = held_q;
		if (rec && held_vld_q && !stall) begin
			push           = 1'b1;
			push_data.last = 1'b0;
		end
		if (state_q == ST_FIN && can_push) begin
			push = 1'b1;
			if (held_vld_q) begin
				push_data.last = 1'b1;
			end else begin
				push_data = '{kind: hts_pkg::KIND_DONE, job: 8'd0, slot_index: 4'd0, last: 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (push) begin
			rsp_q <= push_data;
		end
		if (state_q == ST_ADD) begin
			if (free) begin
				held_q <= '{kind: hts_pkg::KIND_SLOT, job: 8'd0, slot_index: 4'(idx_q), last: 1'b0};
			end else begin
				held_q <= '{kind: hts_pkg::KIND_FULL, job: 8'd0, slot_index: 4'd0, last: 1'b0};
			end
		end
		if (rec && !stall) begin
			held_q <= '{kind: hts_pkg::KIND_RUN, job: rdata_q.job, slot_index: 4'(idx_q),
				last: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			n_q        <= '0;
			valid_q    <= '0;
			held_vld_q <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (push) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q      <= '0;
						n_q        <= '0;
						held_vld_q <= 1'b0;
						unique case (req.op)
							hts_pkg::OP_TICK, hts_pkg::OP_DISPATCH: begin
								state_q <= ST_SCAN;
							end
							hts_pkg::OP_ADD: begin
								state_q <= ST_ADD;
							end
							hts_pkg::OP_DELETE: begin
								if (32'(req.slot) < SLOTS) begin
									valid_q[IW'(req.slot)] <= 1'b0;
								end
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_ADD: begin
					if (free) begin
						valid_q[idx_q] <= 1'b1;
						held_vld_q     <= 1'b1;
						state_q        <= ST_FIN;
					end else if (last_slot) begin
						held_vld_q <= 1'b1;
						state_q    <= ST_FIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						if (upd.wr) begin
							valid_q[idx_q] <= upd.valid;
						end
						if (rec) begin
							held_vld_q <= 1'b1;
							n_q        <= n_q + hts_pkg::NW'(1);
						end
						if (last_slot) begin
							state_q <= ST_FIN;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				ST_FIN: begin
					if (can_push) begin
						held_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
